FILE: rtl/core/bfea_pkg.sv
// bfea_pkg: shared types and constants of the best-fit extent allocator
// used by bfea_rem, bfea_dp, bfea_ctrl and the top level
package bfea_pkg;

  localparam int DW      = 20;  // offsets, lengths and register values
  localparam int NUM_W   = 20;
  localparam int ESZ_W   = 13;
  localparam int OFF_OUT_W = 19;
  localparam int CFG_IW  = 8;
  localparam int PROD_W  = NUM_W + ESZ_W;

  localparam logic [DW-1:0] POOL_LIMIT    = DW'(512 * 1024);
  localparam logic [DW-1:0] MAX_ALLOC_RST = DW'(131072);

  localparam logic [CFG_IW-1:0] REG_POOL_SIZE = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_MAX_ALLOC = CFG_IW'(1);

  localparam logic OP_ALLOC = 1'b0;

  typedef enum logic [2:0] {
    ST_OK, ST_NO_POOL, ST_TOO_LARGE, ST_NO_FIT, ST_OUTSIDE, ST_FULL
  } status_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_CFG, CMD_INIT, CMD_MUL, CMD_RD, CMD_DIVGO, CMD_EVAL,
    CMD_TAKE_EXACT, CMD_SPLIT_A, CMD_SPLIT_B, CMD_SPLIT_C, CMD_FADV, CMD_FM_AB,
    CMD_FM_A, CMD_FM_B, CMD_FM_INS, CMD_ERD, CMD_EWR, CMD_ECNT, CMD_IRD,
    CMD_IWR, CMD_IW0, CMD_IW1, CMD_FIN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    status_t st;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pool_zero;
    logic op_free;
    logic esz_zero;
    logic too_large;
    logic outside;
    logic n_zero;
    logic scan_end;
    logic full;
    logic exact;
    logic found;
    logic bpad_zero;
    logic brest_zero;
    logic rd_lt_off;
    logic cond_a;
    logic cond_b;
    logic rem_busy;
    logic out_free;
    logic erase_end;
    logic ins_end;
    logic ins_two;
    logic cfg_pool;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_MUL, S_CHECK, S_SRD, S_SWAIT, S_DIV, S_EVAL, S_SEND,
    S_FRD, S_FWAIT, S_FMERGE, S_ERD, S_EWR, S_IRD, S_IWR, S_IW0, S_IW1, S_FIN
  } state_t;

endpackage

FILE: rtl/core/bfea_rem.sv
// bfea_rem: restoring remainder unit, one quotient bit per cycle
// depends on bfea_pkg for the dividend width
module bfea_rem import bfea_pkg::*; #(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [AW-1:0] divisor,
  output logic          busy,
  output logic [AW-1:0] rem
);

  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]    dvd;
  logic [CNT_W-1:0] cnt;
  logic [AW:0]      trial;

  assign trial = {rem, dvd[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      dvd  <= dividend;
      rem  <= '0;
      cnt  <= CNT_W'(DW - 1);
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= AW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[AW-1:0];
      end
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/bfea_dp.sv
// bfea_dp: extent table memory, request registers and arithmetic
// depends on bfea_pkg and bfea_rem; driven by commands from bfea_ctrl
module bfea_dp import bfea_pkg::*; #(
  parameter int MAX_EXTENTS    = 32,
  parameter int ALIGN_MULTIPLE = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           st,
  input  logic                 in_op,
  input  logic [NUM_W-1:0]     in_num,
  input  logic [ESZ_W-1:0]     in_esz,
  input  logic [DW-1:0]        in_off,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [DW-1:0]        cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [OFF_OUT_W-1:0] out_offset
);

  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int AW = $clog2(ALIGN_MULTIPLE * (2 ** ESZ_W));

  logic [DW-1:0] start_mem [MAX_EXTENTS];
  logic [DW-1:0] len_mem   [MAX_EXTENTS];

  logic [DW-1:0]     pool, maxa;
  logic [CW-1:0]     count, idx;
  logic              op_q;
  logic [NUM_W-1:0]  num_q;
  logic [ESZ_W-1:0]  esz_q;
  logic [DW-1:0]     off_q;
  logic [PROD_W-1:0] n_full;
  logic [AW-1:0]     align;
  logic [DW-1:0]     rd_s, rd_l, prev_s, prev_l;
  logic [IW-1:0]     best;
  logic [DW-1:0]     best_s, best_l;
  logic [AW-1:0]     best_pad;
  logic              found;
  logic [DW-1:0]     res_off;
  logic [IW-1:0]     ins_p;
  logic [DW-1:0]     ins_a_s, ins_a_l, ins_b_s, ins_b_l;
  logic              ins_two;

  logic [DW-1:0] n;
  logic [AW-1:0] rem, pad;
  logic          rem_busy;
  logic [DW-1:0] pad_ext, best_pad_ext, best_rest;
  logic [CW-1:0] idx_m1, idx_p1;
  logic          fits;

  logic          we, re;
  logic [IW-1:0] wa, ra;
  logic [DW-1:0] ws, wl;

  bfea_rem #(.AW(AW)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == CMD_DIVGO),
    .dividend (rd_s),
    .divisor  (align),
    .busy     (rem_busy),
    .rem      (rem)
  );

  assign n            = n_full[DW-1:0];
  assign pad          = (rem == '0) ? '0 : AW'(align - rem);
  assign pad_ext      = {{(DW-AW){1'b0}}, pad};
  assign best_pad_ext = {{(DW-AW){1'b0}}, best_pad};
  assign best_rest    = best_l - n - best_pad_ext;
  assign idx_m1       = idx - 1'b1;
  assign idx_p1       = idx + 1'b1;
  assign fits         = {1'b0, rd_l} >= ({1'b0, n} + {1'b0, pad_ext});

  always_comb begin
    st.pool_zero  = (pool == '0);
    st.op_free    = (op_q != OP_ALLOC);
    st.esz_zero   = (esz_q == '0);
    st.too_large  = (n_full > PROD_W'(pool)) || (n_full > PROD_W'(maxa));
    st.outside    = (off_q >= pool) ||
                    (((PROD_W + 1)'(off_q) + {1'b0, n_full}) > (PROD_W + 1)'(pool));
    st.n_zero     = (n_full == '0);
    st.scan_end   = (idx == count);
    st.full       = (count == CW'(MAX_EXTENTS));
    st.exact      = (rd_l == n) && (rem == '0);
    st.found      = found;
    st.bpad_zero  = (best_pad == '0);
    st.brest_zero = (best_rest == '0);
    st.rd_lt_off  = (rd_s < off_q);
    st.cond_a     = (idx < count) && (({1'b0, off_q} + {1'b0, n}) == {1'b0, rd_s});
    st.cond_b     = (idx != '0) && (({1'b0, prev_s} + {1'b0, prev_l}) == {1'b0, off_q});
    st.rem_busy   = rem_busy;
    st.out_free   = !out_valid || out_ready;
    st.erase_end  = (idx_p1 >= count);
    st.ins_end    = (idx == CW'(ins_p));
    st.ins_two    = ins_two;
    st.cfg_pool   = (cfg_index == REG_POOL_SIZE);
  end

  // table port select
  always_comb begin
    we = 1'b1;
    wa = idx[IW-1:0];
    ws = rd_s;
    wl = rd_l;
    re = 1'b1;
    ra = idx[IW-1:0];
    case (cmd.op)
      CMD_INIT: begin
        wa = '0;
        ws = '0;
        wl = pool;
      end
      CMD_SPLIT_A: begin
        wa = best;
        ws = best_s + n;
        wl = best_l - n;
      end
      CMD_SPLIT_B: begin
        wa = best;
        ws = best_s;
        wl = best_pad_ext;
      end
      CMD_FM_AB: begin
        wa = idx_m1[IW-1:0];
        ws = prev_s;
        wl = prev_l + rd_l + n;
      end
      CMD_FM_A: begin
        ws = off_q;
        wl = rd_l + n;
      end
      CMD_FM_B: begin
        wa = idx_m1[IW-1:0];
        ws = prev_s;
        wl = prev_l + n;
      end
      CMD_EWR, CMD_IWR: begin
      end
      CMD_IW0: begin
        wa = ins_p;
        ws = ins_a_s;
        wl = ins_a_l;
      end
      CMD_IW1: begin
        wa = ins_p + 1'b1;
        ws = ins_b_s;
        wl = ins_b_l;
      end
      default: we = 1'b0;
    endcase
    case (cmd.op)
      CMD_RD:  ra = idx[IW-1:0];
      CMD_ERD: ra = idx_p1[IW-1:0];
      CMD_IRD: ra = idx_m1[IW-1:0];
      default: re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      start_mem[wa] <= ws;
      len_mem[wa]   <= wl;
    end
    if (re) begin
      rd_s <= start_mem[ra];
      rd_l <= len_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool      <= POOL_LIMIT;
      maxa      <= MAX_ALLOC_RST;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && cmd.op != CMD_FIN) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        CMD_LOAD: begin
          op_q    <= in_op;
          num_q   <= in_num;
          esz_q   <= in_esz;
          off_q   <= in_off;
          res_off <= '0;
        end
        CMD_CFG: begin
          if (cfg_index == REG_POOL_SIZE) begin
            pool <= (cfg_data > POOL_LIMIT) ? POOL_LIMIT : cfg_data;
          end else if (cfg_index == REG_MAX_ALLOC) begin
            maxa <= cfg_data;
          end
        end
        CMD_INIT: count <= (pool != '0) ? CW'(1) : '0;
        CMD_MUL: begin
          n_full <= PROD_W'(num_q) * PROD_W'(esz_q);
          align  <= AW'(esz_q * ALIGN_MULTIPLE);
          idx    <= '0;
          found  <= 1'b0;
        end
        CMD_EVAL: begin
          if (fits && (!found || best_l > rd_l)) begin
            best     <= idx[IW-1:0];
            best_s   <= rd_s;
            best_l   <= rd_l;
            best_pad <= pad;
            found    <= 1'b1;
          end
          idx <= idx_p1;
        end
        CMD_TAKE_EXACT: res_off <= rd_s;
        CMD_SPLIT_A:    res_off <= best_s;
        CMD_SPLIT_B:    res_off <= best_s + best_pad_ext;
        CMD_SPLIT_C: begin
          res_off <= best_s + best_pad_ext;
          ins_p   <= best;
          ins_a_s <= best_s;
          ins_a_l <= best_pad_ext;
          ins_b_s <= best_s + n + best_pad_ext;
          ins_b_l <= best_rest;
          ins_two <= 1'b1;
          idx     <= count;
        end
        CMD_FADV: begin
          prev_s <= rd_s;
          prev_l <= rd_l;
          idx    <= idx_p1;
        end
        CMD_FM_INS: begin
          ins_p   <= idx[IW-1:0];
          ins_a_s <= off_q;
          ins_a_l <= n;
          ins_two <= 1'b0;
          idx     <= count;
        end
        CMD_EWR:  idx   <= idx_p1;
        CMD_ECNT: count <= count - 1'b1;
        CMD_IWR:  idx   <= idx_m1;
        CMD_IW0:  count <= count + 1'b1;
        CMD_FIN: begin
          out_valid  <= 1'b1;
          out_status <= cmd.st;
          out_offset <= (cmd.st == ST_OK) ? res_off[OFF_OUT_W-1:0] : '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/bfea_ctrl.sv
// bfea_ctrl: sequencer for scan, split, merge and table shifting
// depends on bfea_pkg; commands bfea_dp and reads its status
module bfea_ctrl import bfea_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t st,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t  state, state_next;
  status_t res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      res   <= ST_OK;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd.op     = CMD_NONE;
    cmd.st     = res;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.op = CMD_CFG;
          if (st.cfg_pool) state_next = S_INIT;
        end else if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_MUL;
        end
      end
      S_INIT: begin
        cmd.op     = CMD_INIT;
        state_next = S_IDLE;
      end
      S_MUL: begin
        cmd.op     = CMD_MUL;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        res_next   = ST_OK;
        state_next = S_FIN;
        if (st.pool_zero) begin
          res_next = ST_NO_POOL;
        end else if (!st.op_free) begin
          if (st.esz_zero) res_next = ST_NO_FIT;
          else if (st.too_large) res_next = ST_TOO_LARGE;
          else state_next = S_SRD;
        end else begin
          if (st.outside) res_next = ST_OUTSIDE;
          else if (!st.n_zero) state_next = S_FRD;
        end
      end
      S_SRD: begin
        if (st.scan_end) begin
          state_next = S_SEND;
        end else begin
          cmd.op     = CMD_RD;
          state_next = S_SWAIT;
        end
      end
      S_SWAIT: begin
        cmd.op     = CMD_DIVGO;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!st.rem_busy) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (st.exact) begin
          cmd.op     = CMD_TAKE_EXACT;
          state_next = S_ERD;
        end else begin
          cmd.op     = CMD_EVAL;
          state_next = S_SRD;
        end
      end
      S_SEND: begin
        state_next = S_FIN;
        if (!st.found) begin
          res_next = ST_NO_FIT;
        end else if (st.bpad_zero) begin
          cmd.op = CMD_SPLIT_A;
        end else if (st.brest_zero) begin
          cmd.op = CMD_SPLIT_B;
        end else if (st.full) begin
          res_next = ST_FULL;
        end else begin
          cmd.op     = CMD_SPLIT_C;
          state_next = S_IRD;
        end
      end
      S_FRD: begin
        if (st.scan_end) begin
          state_next = S_FMERGE;
        end else begin
          cmd.op     = CMD_RD;
          state_next = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (st.rd_lt_off) begin
          cmd.op     = CMD_FADV;
          state_next = S_FRD;
        end else begin
          state_next = S_FMERGE;
        end
      end
      S_FMERGE: begin
        state_next = S_FIN;
        if (st.cond_a && st.cond_b) begin
          cmd.op     = CMD_FM_AB;
          state_next = S_ERD;
        end else if (st.cond_a) begin
          cmd.op = CMD_FM_A;
        end else if (st.cond_b) begin
          cmd.op = CMD_FM_B;
        end else if (st.full) begin
          res_next = ST_FULL;
        end else begin
          cmd.op     = CMD_FM_INS;
          state_next = S_IRD;
        end
      end
      S_ERD: begin
        if (st.erase_end) begin
          cmd.op     = CMD_ECNT;
          state_next = S_FIN;
        end else begin
          cmd.op     = CMD_ERD;
          state_next = S_EWR;
        end
      end
      S_EWR: begin
        cmd.op     = CMD_EWR;
        state_next = S_ERD;
      end
      S_IRD: begin
        if (st.ins_end) begin
          state_next = S_IW0;
        end else begin
          cmd.op     = CMD_IRD;
          state_next = S_IWR;
        end
      end
      S_IWR: begin
        cmd.op     = CMD_IWR;
        state_next = S_IRD;
      end
      S_IW0: begin
        cmd.op     = CMD_IW0;
        state_next = st.ins_two ? S_IW1 : S_FIN;
      end
      S_IW1: begin
        cmd.op     = CMD_IW1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.op     = CMD_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/best_fit_extent_allocator.sv
// best_fit_extent_allocator: top level of the best-fit extent allocator
// depends on bfea_pkg, bfea_ctrl, bfea_dp (and bfea_rem below it)
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata request, tuser op
//  m_axis    out  m_axis_tvalid/tready      tdata status and offset
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// one request at a time; a free reads the extents in order up to the freed offset,
// an allocate scans the table entries in order, using the one-bit-per-cycle
// remainder unit to find each extent's padding
// inserting or erasing an entry moves each later entry with a table read, then a write
// reset and every pool_size write rebuild the table from the pool size
// a result waits in the output register; the next request is taken meanwhile
module best_fit_extent_allocator import bfea_pkg::*; #(
  parameter int MAX_EXTENTS    = 32,
  parameter int ALIGN_MULTIPLE = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [55:0]       s_axis_tdata,  // element count, element bytes, free_offset
  input  logic [0:0]        s_axis_tuser,  // op
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,  // status, alloc_offset
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [DW-1:0]     cfg_data
);

  ctrl_cmd_t            cmd;
  dp_status_t           st;
  logic                 busy;
  logic [2:0]           out_status;
  logic [OFF_OUT_W-1:0] out_offset;

  bfea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .st        (st),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .busy      (busy)
  );

  bfea_dp #(
    .MAX_EXTENTS    (MAX_EXTENTS),
    .ALIGN_MULTIPLE (ALIGN_MULTIPLE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_op      (s_axis_tuser[0]),
    .in_num     (s_axis_tdata[19:0]),
    .in_esz     (s_axis_tdata[32:20]),
    .in_off     (s_axis_tdata[52:33]),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_offset (out_offset)
  );

  assign m_axis_tdata = {2'b00, out_offset, out_status};

  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tvalid && s_axis_tready && cfg_valid && cfg_ready))
    else $error("request and config beat taken together");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (busy && !s_axis_tready))
    else $error("request taken while previous one in progress");

  a_init_after_pool: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_POOL_SIZE) |=> (cmd.op == CMD_INIT))
    else $error("pool write without table rebuild");

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_FIN) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrites waiting beat");

endmodule

FILE: tb/best_fit_extent_allocator_tb.sv
// best_fit_extent_allocator_tb: self-checking bench for the best-fit extent allocator
// holds its own model of the extent table in a scoreboard class; needs bfea_pkg and the rtl
module best_fit_extent_allocator_tb import bfea_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 32;
  localparam int ALIGN_MUL   = 2;
  localparam int STALL_LIMIT = 50000;
  localparam int LONG_HOLD   = 3000;
  localparam logic OP_FREE   = 1'b1;

  class alloc_scoreboard;
    longint unsigned pool_bytes;
    longint unsigned max_bytes;
    longint unsigned ext_start[TABLE_DEPTH];
    longint unsigned ext_len[TABLE_DEPTH];
    int unsigned ext_cnt;
    logic [23:0] pending[$];
    int mismatches;
    int failures;

    function new();
      pool_bytes = 64'(POOL_LIMIT);
      max_bytes  = 64'(MAX_ALLOC_RST);
      rebuild();
      mismatches = 0;
      failures   = 0;
    endfunction

    function void rebuild();
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        ext_start[k] = 0;
        ext_len[k]   = 0;
      end
      ext_len[0] = pool_bytes;
      ext_cnt = (pool_bytes != 0) ? 1 : 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [DW-1:0] val);
      if (idx == REG_POOL_SIZE) begin
        pool_bytes = 64'((val > POOL_LIMIT) ? POOL_LIMIT : val);
        rebuild();
      end else if (idx == REG_MAX_ALLOC) begin
        max_bytes = 64'(val);
      end
    endfunction

    function void drop_entry(int unsigned pos);
      for (int unsigned k = pos; k + 1 < ext_cnt; k++) begin
        ext_start[k] = ext_start[k+1];
        ext_len[k]   = ext_len[k+1];
      end
      ext_cnt--;
    endfunction

    function void add_entry(int unsigned pos, longint unsigned s, longint unsigned l);
      for (int unsigned k = ext_cnt; k > pos; k--) begin
        ext_start[k] = ext_start[k-1];
        ext_len[k]   = ext_len[k-1];
      end
      ext_start[pos] = s;
      ext_len[pos]   = l;
      ext_cnt++;
    endfunction

    function longint unsigned padding(longint unsigned off, longint unsigned align);
      longint unsigned m;
      m = off % align;
      return (m != 0) ? align - m : 0;
    endfunction

    function status_t grant(longint unsigned num, longint unsigned esz,
                            output longint unsigned granted);
      longint unsigned n, align, pad, s, l;
      int unsigned best;
      bit found;
      granted = 0;
      best = 0;
      found = 0;
      if (esz == 0) return ST_NO_FIT;
      n = num * esz;
      if (n > pool_bytes || n > max_bytes) return ST_TOO_LARGE;
      align = ALIGN_MUL * esz;
      for (int unsigned k = 0; k < ext_cnt; k++) begin
        s = ext_start[k];
        l = ext_len[k];
        pad = padding(s, align);
        if (l == n && pad == 0) begin
          drop_entry(k);
          granted = s;
          return ST_OK;
        end
        if (l >= n + pad && (!found || ext_len[best] > l)) begin
          best = k;
          found = 1;
        end
      end
      if (!found) return ST_NO_FIT;
      s = ext_start[best];
      l = ext_len[best];
      pad = padding(s, align);
      if (pad == 0) begin
        ext_start[best] = s + n;
        ext_len[best]   = l - n;
      end else if (l - n - pad == 0) begin
        ext_len[best] = pad;
      end else begin
        if (ext_cnt >= TABLE_DEPTH) return ST_FULL;
        ext_start[best] = s + n + pad;
        ext_len[best]   = l - n - pad;
        add_entry(best, s, pad);
      end
      granted = s + pad;
      return ST_OK;
    endfunction

    function status_t release_extent(longint unsigned num, longint unsigned esz,
                                     longint unsigned off);
      longint unsigned n, rem;
      int unsigned i;
      n = num * esz;
      i = 0;
      if (off >= pool_bytes || off + n > pool_bytes) return ST_OUTSIDE;
      if (n == 0) return ST_OK;
      while (i < ext_cnt && ext_start[i] < off) i++;
      rem = n;
      if (i < ext_cnt && off + rem == ext_start[i]) begin
        ext_start[i] = off;
        ext_len[i]   = ext_len[i] + rem;
        rem = 0;
      end
      if (i > 0 && ext_start[i-1] + ext_len[i-1] == off) begin
        if (rem != 0) begin
          ext_len[i-1] = ext_len[i-1] + rem;
          rem = 0;
        end else begin
          ext_len[i-1] += ext_len[i];
          drop_entry(i);
        end
      end
      if (rem != 0) begin
        if (ext_cnt >= TABLE_DEPTH) return ST_FULL;
        add_entry(i, off, rem);
      end
      return ST_OK;
    endfunction

    // predicts one request, queues and returns the expected result beat
    function logic [23:0] note_request(logic op, logic [NUM_W-1:0] num,
                                       logic [ESZ_W-1:0] esz, logic [DW-1:0] off);
      status_t st;
      longint unsigned granted;
      logic [23:0] beat;
      granted = 0;
      if (pool_bytes == 0) st = ST_NO_POOL;
      else if (op == OP_ALLOC) st = grant(num, esz, granted);
      else st = release_extent(num, esz, off);
      if (st != ST_OK) granted = 0;
      beat = {2'b00, granted[OFF_OUT_W-1:0], st};
      pending.insert(pending.size(), beat);
      return beat;
    endfunction

    function void check_result(logic [23:0] got);
      logic [23:0] want;
      if (pending.size() == 0) begin
        failures++;
        if (mismatches++ < 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got[2:0] !== want[2:0] || got[21:3] !== want[21:3] || got[23:22] !== 2'b00) begin
        failures++;
        if (mismatches++ < 10)
          $display("mismatch: status exp %0d got %0d, offset exp %0d got %0d",
                   want[2:0], got[2:0], want[21:3], got[21:3]);
      end
    endfunction
  endclass

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [ESZ_W-1:0] esz;
    logic [DW-1:0]    off;
  } live_block_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [55:0]       s_axis_tdata;  // element count, element bytes, free_offset
  logic [0:0]        s_axis_tuser;  // op
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [23:0]       m_axis_tdata;  // status, alloc_offset
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [DW-1:0]     cfg_data;

  alloc_scoreboard sb;
  live_block_t live[$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int quiet_cycles;

  best_fit_extent_allocator dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_request(logic op, logic [NUM_W-1:0] num,
                              logic [ESZ_W-1:0] esz, logic [DW-1:0] off);
    logic [23:0] beat;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, off, esz, num};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beat = sb.note_request(op, num, esz, off);
    if (op == OP_ALLOC && beat[2:0] == ST_OK && num * esz != 0)
      live.insert(live.size(), '{num, esz, DW'(beat[21:3])});
  endtask

  // wait until the block has drained, then leave the input low
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [ESZ_W-1:0] pick_esz();
    case ($urandom_range(0, 9))
      0: return ESZ_W'($urandom_range(0, 8191));
      1: return ESZ_W'(1 << $urandom_range(0, 12));
      2: return ESZ_W'($urandom_range(1, 4096));
      default: return ESZ_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic random_request();
    int k;
    live_block_t b;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_request(OP_ALLOC, NUM_W'($urandom_range(0, 40)), pick_esz(), DW'($urandom));
    end else if (r < 85 && live.size() != 0) begin
      k = $urandom_range(0, live.size() - 1);
      b = live[k];
      live.delete(k);
      send_request(OP_FREE, b.num, b.esz, b.off);
    end else if (r < 90) begin
      send_request(OP_ALLOC, NUM_W'($urandom), ESZ_W'($urandom), DW'($urandom));
    end else if (r < 95) begin
      send_request(OP_FREE, NUM_W'($urandom_range(0, 8)), pick_esz(),
                   DW'($urandom_range(0, 32'(sb.pool_bytes + 16))));
    end else begin
      send_request(OP_FREE, NUM_W'($urandom), ESZ_W'($urandom), DW'($urandom));
    end
  endtask

  initial begin
    logic [DW-1:0] pools[8];
    logic [DW-1:0] limits[8];
    int idle_mode[8][2];
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and the named corner cases at reset settings
    send_request(OP_ALLOC, 20'd1, 13'd1, 20'd0);
    send_request(OP_ALLOC, 20'd3, 13'd5, 20'd0);          // padding in front
    send_request(OP_ALLOC, 20'd0, 13'd7, 20'd0);          // zero-byte allocate
    send_request(OP_ALLOC, 20'd9, 13'd0, 20'd0);          // zero element size
    send_request(OP_ALLOC, 20'hFFFFF, 13'h1FFF, 20'hFFFFF);
    send_request(OP_ALLOC, 20'd32, 13'd4096, 20'd0);      // at max_allocation
    send_request(OP_ALLOC, 20'd33, 13'd4096, 20'd0);      // too large
    send_request(OP_FREE, 20'd1, 13'd1, 20'hFFFFF);       // outside pool
    send_request(OP_FREE, 20'd2, 13'd1, 20'd524287);      // runs past the end
    send_request(OP_FREE, 20'd0, 13'd8, 20'd100);         // zero-byte free
    while (live.size() != 0) begin
      send_request(OP_FREE, live[0].num, live[0].esz, live[0].off);
      void'(live.pop_front());
    end
    send_request(OP_FREE, 20'd1, 13'd1, 20'd0);           // double free
    drain();
    write_reg(REG_MAX_ALLOC, 20'hFFFFF);
    write_reg(REG_POOL_SIZE, 20'hFFFFF);                  // clamps to the limit
    write_reg(8'hFF, 20'h5A5A5);                          // unused index
    send_request(OP_ALLOC, 20'd524288, 13'd1, 20'd0);     // whole pool, exact
    send_request(OP_ALLOC, 20'd1, 13'd1, 20'd0);          // no fit
    send_request(OP_FREE, 20'd524288, 13'd1, 20'd0);
    live.delete();

    pools  = '{20'd524288, 20'd4096, 20'd0, 20'd1, 20'd65536, 20'd2048, 20'd16384, 20'd8192};
    limits = '{20'd131072, 20'd1048575, 20'd4096, 20'd0, 20'd65536, 20'd1024, 20'd524288,
               20'd2048};
    idle_mode = '{'{0, 0}, '{62, 0}, '{0, 62}, '{33, 33}, '{0, 0}, '{62, 0}, '{0, 62},
                  '{33, 33}};
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      live.delete();
      write_reg(REG_MAX_ALLOC, (ph == 3) ? DW'($urandom) : limits[ph]);
      write_reg(REG_POOL_SIZE, (ph == 7) ? DW'($urandom_range(64, 32768)) : pools[ph]);
      send_idle_pct  = idle_mode[ph][0];
      recv_stall_pct = idle_mode[ph][1];
      for (int i = 0; i < 235; i++) begin
        if (ph == 4 && i == 20) hold_cycles = LONG_HOLD;
        random_request();
      end
    end

    drain();
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bfea_pkg.sv
rtl/core/bfea_rem.sv
rtl/core/bfea_dp.sv
rtl/core/bfea_ctrl.sv
rtl/core/best_fit_extent_allocator.sv
tb/best_fit_extent_allocator_tb.sv
